/* rtl/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// pcs_pkg: shared types, constants and table builders
// Mode codes, register indexes, side-band struct and the log2/exp2 table builders.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

  localparam int TIB_DEFAULT = 6;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_POINT = 2'd1,
    MODE_AXIS  = 2'd2
  } mode_t;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_POWER = 1'b1;

  // side-band info that rides along with every item
  typedef struct packed {
    logic [1:0] mode;
    logic       uneg;   // base u was negative
    logic       vzero;  // power forced to zero
  } side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // log2(1 + i/N) in Q.16 by repeated squaring
  function automatic logic [16:0] log_entry(input int tib, input int i);
    logic [63:0] z;
    logic [63:0] acc;
    z   = 64'((1 << tib) + i) << (30 - tib);
    acc = '0;
    for (int j = 0; j < 16; j++) begin
      z   = (z * z) >> 30;
      acc = acc << 1;
      if (z >= (64'd1 << 31)) begin
        acc = acc | 64'd1;
        z   = z >> 1;
      end
    end
    if (i == (1 << tib)) begin
      acc = 64'd65536;
    end
    return 17'(acc);
  endfunction

  // 2^(i/N) in Q.30 as a product of square-root chain terms
  function automatic logic [31:0] exp_entry(input int tib, input int i);
    logic [63:0] r;
    logic [63:0] e;
    r = 64'd1 << 31;
    e = 64'd1 << 30;
    for (int j = 1; j <= tib; j++) begin
      r = isqrt64(r << 30);
      if (((i >> (tib - j)) & 1) != 0) begin
        e = (e * r) >> 30;
      end
    end
    if (i == (1 << tib)) begin
      e = 64'd1 << 31;
    end
    return 32'(e);
  endfunction

  // linear step from a toward b, magnitude truncated
  function automatic logic [31:0] lerp(input logic [31:0] a, input logic [31:0] b,
                                       input logic [15:0] rem, input int rb);
    logic [63:0] d;
    logic [63:0] pr;
    if (b >= a) begin
      d  = 64'(b - a);
      pr = (d * 64'(rem)) >> rb;
      return a + 32'(pr);
    end
    d  = 64'(a - b);
    pr = (d * 64'(rem)) >> rb;
    return a - 32'(pr);
  endfunction

endpackage

`default_nettype wire

/* rtl/power_curve_shaper.sv */
// ----------------------------------------------------------------------------
// power_curve_shaper: pipelined power-curve sample shaper
// Maps a Q1.15 sample through |u|^k, k = 2^p, in none, axis or point mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one Q1.15 sample per item.
//   Output channel out_valid/out_ready returns one Q2.15 sample plus a
//   saturated flag per item, in input order.
//   The stages from input accept to out_valid are input prep,
//   three log2 stages, two scaling stages, two exp2 stages and the
//   output register. Throughput is one item per cycle while out_ready is high.
//   Each stage holds its item while the next stage is full and stalled, so a
//   stall at out_ready backs up stage by stage; bubbles are squeezed out and
//   in_ready only drops when every stage holds an item.
//   Reset (rst_n low, synchronous) empties the pipeline and sets mode
//   to none and power_log2 to 0 (k = 1).
//   Registers (APB, 32-bit data): 0x0 mode, 0x4 power_log2. Write only
//   while the pipeline is empty. The exponent factor is re-derived from
//   the stored power_log2 value through a register.
// ----------------------------------------------------------------------------
`default_nettype none

module power_curve_shaper import pcs_pkg::*; #(
  parameter int TABLE_INDEX_BITS = TIB_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_sample_out,
  output logic               out_saturated,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int NSTG = 9;
  localparam int R    = 16 - TABLE_INDEX_BITS;
  localparam int N    = 1 << TABLE_INDEX_BITS;

  // ---------------- configuration ----------------
  logic [1:0]  mode_r;
  logic [15:0] plog_r;
  logic        wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      plog_r <= '0;
    end else if (wr) begin
      unique case (cfg_paddr[2])
        REG_MODE:  mode_r <= cfg_pwdata[1:0];
        REG_POWER: plog_r <= cfg_pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MODE:  cfg_prdata = {30'd0, mode_r};
      REG_POWER: cfg_prdata = {16'd0, plog_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // exponent factor k: biased p splits into shift and fractional root
  logic [31:0] et [N+1];
  for (genvar gi = 0; gi <= N; gi++) begin : g_et
    assign et[gi] = exp_entry(TABLE_INDEX_BITS, gi);
  end

  logic [15:0] pb, kfr;
  logic [TABLE_INDEX_BITS:0] kidx0, kidx1;
  logic [31:0] kf_r;
  logic [5:0]  ksh_r;

  assign pb    = plog_r ^ 16'h8000;
  assign kfr   = {pb[11:0], 4'd0};
  assign kidx0 = {1'b0, kfr[15:R]};
  assign kidx1 = kidx0 + 1'b1;

  always_ff @(posedge clk) begin
    kf_r  <= lerp(et[kidx0], et[kidx1], 16'(kfr[R-1:0]), R);
    ksh_r <= 6'd38 - 6'(pb[15:12]);   // 30 - (pb[15:12] - 8)
  end

  // ---------------- pipeline control ----------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];

  // ---------------- stage A: base selection ----------------
  logic signed [17:0] u;
  logic [16:0] m_nxt, m_r;
  side_t       side_nxt, side_a_r;

  always_comb begin
    u        = {in_sample_in[15], in_sample_in, 1'b0} - 18'sd32768;
    side_nxt = '{mode: mode_r, uneg: 1'b0, vzero: 1'b0};
    if (mode_r == MODE_POINT || mode_r == MODE_AXIS) begin
      m_nxt          = u[17] ? 17'(-u) : 17'(u);
      side_nxt.uneg  = u[17];
      side_nxt.vzero = (m_nxt == '0);
    end else begin
      // negative base has no real power: output zero
      m_nxt          = in_sample_in[15] ? '0 : 17'(in_sample_in);
      side_nxt.vzero = (in_sample_in <= 16'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_r      <= m_nxt;
      side_a_r <= side_nxt;
    end
  end

  // ---------------- log2, scale, exp2 ----------------
  logic signed [21:0] lval;
  logic signed [31:0] tval;
  side_t side_d, side_f, side_h;
  logic [31:0] ef;
  logic huge, shz;
  logic [5:0] sh;

  pcs_log #(.TIB(TABLE_INDEX_BITS)) u_log (
    .clk      (clk),
    .en       (en[3:1]),
    .mag      (m_r),
    .side_in  (side_a_r),
    .lval     (lval),
    .side_out (side_d)
  );

  pcs_mul u_mul (
    .clk      (clk),
    .en       (en[5:4]),
    .lval     (lval),
    .side_in  (side_d),
    .kf       (kf_r),
    .ksh      (ksh_r),
    .tval     (tval),
    .side_out (side_f)
  );

  pcs_exp #(.TIB(TABLE_INDEX_BITS)) u_exp (
    .clk      (clk),
    .en       (en[7:6]),
    .tval     (tval),
    .side_in  (side_f),
    .ef       (ef),
    .huge     (huge),
    .shz      (shz),
    .sh       (sh),
    .side_out (side_h)
  );

  // ---------------- output: final shift, mode combine, saturate ----------------
  logic [20:0]        vv;
  logic signed [22:0] vs, q, y;
  logic signed [16:0] y_nxt, y_r;
  logic               sat_nxt, sat_r;

  always_comb begin
    if (side_h.vzero)      vv = '0;
    else if (huge)         vv = 21'd1 << 20;   // true power >= 8, saturates
    else if (shz)          vv = '0;
    else                   vv = 21'(ef >> sh);
    vs = $signed({2'b00, vv});
    if (side_h.mode == MODE_POINT) begin
      q = side_h.uneg ? (23'sd32768 - vs) : (vs + 23'sd32768);
      y = q >>> 1;
    end else begin
      q = '0;
      y = vs;
    end
    sat_nxt = 1'b1;
    if (y > 23'sd65535)       y_nxt = 17'sd65535;
    else if (y < -23'sd65536) y_nxt = -17'sd65536;
    else begin
      y_nxt   = y[16:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      y_r   <= y_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_sample_out = y_r;
  assign out_saturated  = sat_r;

endmodule

`default_nettype wire

/* rtl/pcs_log.sv */
// ----------------------------------------------------------------------------
// pcs_log: three-stage log2 of the base magnitude
// Leading-one normalize, table fetch, interpolate and add exponent.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_log import pcs_pkg::*; #(
  parameter int TIB = TIB_DEFAULT
) (
  input  logic               clk,
  input  logic [2:0]         en,
  input  logic [16:0]        mag,
  input  side_t              side_in,
  output logic signed [21:0] lval,
  output side_t              side_out
);

  localparam int N = 1 << TIB;
  localparam int R = 16 - TIB;

  logic [16:0] lt [N+1];
  for (genvar gi = 0; gi <= N; gi++) begin : g_lt
    assign lt[gi] = log_entry(TIB, gi);
  end

  // stage B
  logic [4:0]  e_nxt, e_b_r;
  logic [15:0] f_nxt, f_r;
  logic [32:0] shv;
  side_t       side_b_r;

  always_comb begin
    e_nxt = '0;
    for (int b = 1; b < 17; b++) begin
      if (mag[b]) e_nxt = 5'(b);
    end
    shv   = {16'd0, mag} << (5'd16 - e_nxt);
    f_nxt = shv[15:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      e_b_r    <= e_nxt;
      f_r      <= f_nxt;
      side_b_r <= side_in;
    end
  end

  // stage C: table fetch
  logic [TIB:0] idx0, idx1;
  logic [16:0]  a_r, b_r;
  logic [15:0]  rem_r;
  logic [4:0]   e_c_r;
  side_t        side_c_r;

  assign idx0 = {1'b0, f_r[15:R]};
  assign idx1 = idx0 + 1'b1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a_r      <= lt[idx0];
      b_r      <= lt[idx1];
      rem_r    <= 16'(f_r[R-1:0]);
      e_c_r    <= e_b_r;
      side_c_r <= side_b_r;
    end
  end

  // stage D: interpolate, add integer part (e - 15)
  logic [31:0] val;
  logic [21:0] l_nxt;
  logic signed [21:0] l_r;
  side_t       side_d_r;

  assign val   = lerp(32'(a_r), 32'(b_r), rem_r, R);
  assign l_nxt = 22'({e_c_r, 16'd0}) - 22'(983040) + 22'(val);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      l_r      <= $signed(l_nxt);
      side_d_r <= side_c_r;
    end
  end

  assign lval     = l_r;
  assign side_out = side_d_r;

endmodule

`default_nettype wire

/* rtl/pcs_mul.sv */
// ----------------------------------------------------------------------------
// pcs_mul: two-stage exponent scaling
// t = sign(L) * ((|L| * kf) >> ksh), multiply then shift.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_mul import pcs_pkg::*; (
  input  logic               clk,
  input  logic [1:0]         en,
  input  logic signed [21:0] lval,
  input  side_t              side_in,
  input  logic [31:0]        kf,
  input  logic [5:0]         ksh,
  output logic signed [31:0] tval,
  output side_t              side_out
);

  logic [20:0] lmag;
  logic [52:0] prod_r;
  logic        lneg_r;
  side_t       side_e_r;

  assign lmag = lval[21] ? 21'(-lval) : 21'(lval);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r   <= 53'(lmag) * 53'(kf);
      lneg_r   <= lval[21];
      side_e_r <= side_in;
    end
  end

  logic [52:0] tmag;
  logic [31:0] t_nxt;
  logic signed [31:0] t_r;
  side_t       side_f_r;

  assign tmag  = prod_r >> ksh;
  assign t_nxt = lneg_r ? -32'(tmag) : 32'(tmag);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_r      <= $signed(t_nxt);
      side_f_r <= side_e_r;
    end
  end

  assign tval     = t_r;
  assign side_out = side_f_r;

endmodule

`default_nettype wire

/* rtl/pcs_exp.sv */
// ----------------------------------------------------------------------------
// pcs_exp: two-stage exp2 of the scaled log
// Split t, fetch table pair, interpolate; shift is applied downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_exp import pcs_pkg::*; #(
  parameter int TIB = TIB_DEFAULT
) (
  input  logic               clk,
  input  logic [1:0]         en,
  input  logic signed [31:0] tval,
  input  side_t              side_in,
  output logic [31:0]        ef,
  output logic               huge,
  output logic               shz,
  output logic [5:0]         sh,
  output side_t              side_out
);

  localparam int N = 1 << TIB;
  localparam int R = 16 - TIB;

  logic [31:0] et [N+1];
  for (genvar gi = 0; gi <= N; gi++) begin : g_et
    assign et[gi] = exp_entry(TIB, gi);
  end

  // stage G
  logic signed [15:0] ti;
  logic signed [16:0] shv;
  logic [TIB:0]       idx0, idx1;
  logic [31:0]        a_r, b_r;
  logic [15:0]        rem_r;
  logic               huge_g_r, shz_g_r;
  logic [5:0]         sh_g_r;
  side_t              side_g_r;

  assign ti   = tval[31:16];
  assign shv  = 17'sd15 - {ti[15], ti};
  assign idx0 = {1'b0, tval[15:R]};
  assign idx1 = idx0 + 1'b1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r      <= et[idx0];
      b_r      <= et[idx1];
      rem_r    <= 16'(tval[R-1:0]);
      huge_g_r <= (ti > 16'sd2);
      shz_g_r  <= (shv > 17'sd40);
      sh_g_r   <= shv[5:0];
      side_g_r <= side_in;
    end
  end

  // stage H
  logic [31:0] ef_r;
  logic        huge_h_r, shz_h_r;
  logic [5:0]  sh_h_r;
  side_t       side_h_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ef_r     <= lerp(a_r, b_r, rem_r, R);
      huge_h_r <= huge_g_r;
      shz_h_r  <= shz_g_r;
      sh_h_r   <= sh_g_r;
      side_h_r <= side_g_r;
    end
  end

  assign ef       = ef_r;
  assign huge     = huge_h_r;
  assign shz      = shz_h_r;
  assign sh       = sh_h_r;
  assign side_out = side_h_r;

endmodule

`default_nettype wire
